### rtl/assert_macros.svh
// Assertion macros shared by the controller RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the block clock, switched off during reset
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must never hold outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

### rtl/tapdc_pkg.sv
// Package: types, constants and register codes of the two-axis controller
`timescale 1ns / 1ps

package tapdc_pkg;

   // default parameter values
   localparam int POS_BITS_DEF       = 12;
   localparam int COEF_FRAC_BITS_DEF = 16;

   // fixed field widths
   localparam int COEF_BITS   = 20;
   localparam int ERR_BITS    = 16;
   localparam int SUM_BITS    = 9;
   localparam int DRIVE_BITS  = 16;
   localparam int CSR_IDX_BITS = 2;

   // integral limit and per-axis divisors
   localparam int SUM_LIMIT = 250;
   localparam int DIV_X     = 20;
   localparam int DIV_Y     = 12;

   // coefficient reset values (Q16)
   localparam logic [COEF_BITS-1:0] COEF_NOW_RST   = COEF_BITS'(38339);
   localparam logic [COEF_BITS-1:0] COEF_PREV_RST  = COEF_BITS'(-39322);
   localparam logic [COEF_BITS-1:0] COEF_PREV2_RST = COEF_BITS'(3277);
   localparam logic [COEF_BITS-1:0] COEF_INT_RST   = COEF_BITS'(8738);

   // register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_ERR_NOW   = 2'd0,
      REG_ERR_PREV  = 2'd1,
      REG_ERR_BACK2 = 2'd2,
      REG_INTEGRAL  = 2'd3
   } reg_idx_type;

   // coefficient set handed to the lanes
   typedef struct packed {
      logic [COEF_BITS-1:0] err_now;
      logic [COEF_BITS-1:0] err_prev;
      logic [COEF_BITS-1:0] err_back2;
      logic [COEF_BITS-1:0] integral;
   } coef_type;

   // pipeline control from the top level to each lane
   typedef struct packed {
      logic load_state;   // request accepted: update error history
      logic load_prod;    // stage 2 takes the products
      logic retarget;     // target jumped on this request
   } lane_ctrl_type;

endpackage

### rtl/two_axis_pd_accel_integral_controller_unit.sv
// Two-axis PD controller with acceleration and clamped integral: top level
//
// Usage:
//   req_*  stream of requests: req_tdata carries pos_x, pos_y, ref_x, ref_y
//          (POS_BITS each, from the lowest bit up), req_tuser the retarget flag.
//   rsp_*  one result per request: rsp_tdata carries drive_x then drive_y.
//   csr_*  coefficient writes: csr_index picks the register, csr_data is the
//          20-bit Q(COEF_FRAC_BITS) value; always ready, write while idle.
// Pipeline: an accepted request passes the error history and integral update,
//   the four products per axis, and the sum, floor and saturation into the
//   output register, which raises rsp_tvalid.
// Throughput: one request per cycle unless the result channel stalls; the
//   two axes run as parallel lanes, merged by the output register into one result.
// Reset: coefficients return to their defaults, error history and integrals
//   clear to zero, the pipeline empties.
// Stall: each stage holds while its successor is full and not moving; a
//   request is still taken while a result waits if stage one or two is free.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module two_axis_pd_accel_integral_controller_unit
   import tapdc_pkg::*;
#(
   parameter int POS_BITS       = POS_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
   localparam int REQ_W         = ((4 * POS_BITS + 7) / 8) * 8,
   localparam int RSP_W         = 2 * DRIVE_BITS
)(
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_W-1:0]        req_tdata,   // pos_x, pos_y, ref_x, ref_y, zero pad
   input  logic                    req_tuser,   // retarget
   // result channel
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_W-1:0]        rsp_tdata,   // drive_x, drive_y
   // configuration channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [COEF_BITS-1:0]    csr_data
);

   coef_type coef;

   tapdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coef      (coef)
   );

   // pipeline occupancy and flow
   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;
   logic ready1, ready2, ready3;
   logic load_out;
   lane_ctrl_type ctrl;

   assign ready3 = !v3_ff || rsp_tready;
   assign ready2 = !v2_ff || ready3;
   assign ready1 = !v1_ff || ready2;
   assign req_tready = ready1;

   assign ctrl.load_state = req_tvalid && ready1;
   assign ctrl.load_prod  = v1_ff && ready2;
   assign ctrl.retarget   = req_tuser;
   assign load_out        = v2_ff && ready3;

   assign v1_in = ctrl.load_state || (v1_ff && !ready2);
   assign v2_in = ctrl.load_prod || (v2_ff && !ready3);
   assign v3_in = load_out || (v3_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // axis lanes
   logic signed [DRIVE_BITS-1:0] drive_x, drive_y;

   tapdc_lane #(
      .POS_BITS       (POS_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .DIV            (DIV_X)
   ) u_lane_x (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .pos   (req_tdata[0 +: POS_BITS]),
      .tgt   (req_tdata[2*POS_BITS +: POS_BITS]),
      .coef  (coef),
      .drive (drive_x)
   );

   tapdc_lane #(
      .POS_BITS       (POS_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .DIV            (DIV_Y)
   ) u_lane_y (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .pos   (req_tdata[POS_BITS +: POS_BITS]),
      .tgt   (req_tdata[3*POS_BITS +: POS_BITS]),
      .coef  (coef),
      .drive (drive_y)
   );

   // merge: output register holds both drives
   logic [RSP_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff <= {drive_y, drive_x};
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   `ASSERT_CLK(a_accept_fills, (req_tvalid && req_tready) |=> v1_ff, "accepted request not in stage one")
   `ASSERT_NEVER(a_full_stall, v1_ff && v2_ff && v3_ff && !rsp_tready && req_tready, "request taken into a full stalled pipe")
   `ASSERT_CLK(a_drain, (rsp_tvalid && rsp_tready && !v2_ff) |=> !rsp_tvalid, "result repeated after delivery")

endmodule

### rtl/tapdc_csr.sv
// Coefficient register bank with its write channel
`timescale 1ns / 1ps

module tapdc_csr
   import tapdc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [COEF_BITS-1:0]    csr_data,
   output coef_type                coef
);

   coef_type coef_ff, coef_in;

   // writes are always taken
   assign csr_ready = 1'b1;

   // register decode
   always_comb begin
      coef_in = coef_ff;
      if (csr_valid) begin
         unique case (reg_idx_type'(csr_index))
            REG_ERR_NOW:   coef_in.err_now   = csr_data;
            REG_ERR_PREV:  coef_in.err_prev  = csr_data;
            REG_ERR_BACK2: coef_in.err_back2 = csr_data;
            REG_INTEGRAL:  coef_in.integral  = csr_data;
            default:       coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.err_now   <= COEF_NOW_RST;
         coef_ff.err_prev  <= COEF_PREV_RST;
         coef_ff.err_back2 <= COEF_PREV2_RST;
         coef_ff.integral  <= COEF_INT_RST;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

### rtl/tapdc_lane.sv
// One axis: error history, clamped integral, weighted products and drive
`timescale 1ns / 1ps

module tapdc_lane
   import tapdc_pkg::*;
#(
   parameter int POS_BITS       = POS_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
   parameter int DIV            = DIV_X
)(
   input  logic                         clock,
   input  logic                         reset,
   input  lane_ctrl_type                ctrl,
   input  logic [POS_BITS-1:0]          pos,
   input  logic [POS_BITS-1:0]          tgt,
   input  coef_type                     coef,
   output logic signed [DRIVE_BITS-1:0] drive
);

   // reciprocal for the constant divide, exact for magnitudes below 2^17
   localparam int QSHIFT    = 20;
   localparam int RECIP     = ((1 << QSHIFT) + DIV - 1) / DIV;
   localparam int RECIP_W   = $clog2(RECIP + 1);
   localparam int MQ_W      = POS_BITS + RECIP_W;
   localparam int CALC_W    = 16;
   localparam int PROD_W    = COEF_BITS + ERR_BITS;
   localparam int PSUM_W    = COEF_BITS + SUM_BITS;
   localparam int ACC_W     = PROD_W + 2;
   localparam logic signed [CALC_W-1:0] SUM_HI = CALC_W'(SUM_LIMIT);
   localparam logic signed [CALC_W-1:0] SUM_LO = CALC_W'(-SUM_LIMIT);

   // state: stage 1
   logic signed [ERR_BITS-1:0] now_ff, prev_ff, prev2_ff;
   logic signed [ERR_BITS-1:0] now_in, prev_in, prev2_in;
   logic signed [SUM_BITS-1:0] sum_ff, sum_in;

   // new error, wraps at 16 bits
   logic signed [POS_BITS:0]   enew;
   logic [POS_BITS-1:0]        mag;
   logic [MQ_W-1:0]            mag_prod;
   logic [MQ_W-1:0]            q_full;
   logic signed [CALC_W-1:0]   quot;
   logic signed [CALC_W-1:0]   sum_ext, sum_rnd, sum_half, sum_raw;

   assign enew = signed'({1'b0, tgt}) - signed'({1'b0, pos});
   assign now_in = ERR_BITS'(enew);

   // history shift, or keep the differences on a target jump
   always_comb begin
      if (ctrl.retarget) begin
         prev_in  = now_in + (prev_ff - now_ff);
         prev2_in = prev_in + (prev2_ff - prev_ff);
      end else begin
         prev_in  = now_ff;
         prev2_in = prev_ff;
      end
   end

   // error / DIV, truncated toward zero, by reciprocal on the magnitude
   assign mag      = enew[POS_BITS] ? POS_BITS'(-enew) : POS_BITS'(enew);
   assign mag_prod = MQ_W'(mag) * MQ_W'(RECIP);
   assign q_full   = mag_prod >> QSHIFT;
   assign quot     = enew[POS_BITS] ? -CALC_W'(q_full) : CALC_W'(q_full);

   // halve toward zero on a jump, add, clamp
   always_comb begin
      sum_ext  = CALC_W'(sum_ff);
      sum_rnd  = sum_ext + CALC_W'(sum_ff[SUM_BITS-1]);
      sum_half = ctrl.retarget ? (sum_rnd >>> 1) : sum_ext;
      sum_raw  = sum_half + quot;
      if (sum_raw > SUM_HI) begin
         sum_in = SUM_BITS'(SUM_HI);
      end else if (sum_raw < SUM_LO) begin
         sum_in = SUM_BITS'(SUM_LO);
      end else begin
         sum_in = SUM_BITS'(sum_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff   <= '0;
         prev_ff  <= '0;
         prev2_ff <= '0;
         sum_ff   <= '0;
      end else if (ctrl.load_state) begin
         now_ff   <= now_in;
         prev_ff  <= prev_in;
         prev2_ff <= prev2_in;
         sum_ff   <= sum_in;
      end
   end

   // stage 2: weighted products of the updated state
   logic signed [COEF_BITS-1:0] c_now, c_prev, c_prev2, c_int;
   logic signed [PROD_W-1:0]    p_now_ff, p_prev_ff, p_prev2_ff;
   logic signed [PROD_W-1:0]    p_now_in, p_prev_in, p_prev2_in;
   logic signed [PSUM_W-1:0]    p_int_ff, p_int_in;

   assign c_now   = signed'(coef.err_now);
   assign c_prev  = signed'(coef.err_prev);
   assign c_prev2 = signed'(coef.err_back2);
   assign c_int   = signed'(coef.integral);

   assign p_now_in   = c_now * now_ff;
   assign p_prev_in  = c_prev * prev_ff;
   assign p_prev2_in = c_prev2 * prev2_ff;
   assign p_int_in   = c_int * sum_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load_prod) begin
         p_now_ff   <= p_now_in;
         p_prev_ff  <= p_prev_in;
         p_prev2_ff <= p_prev2_in;
         p_int_ff   <= p_int_in;
      end
   end

   // sum, floor by arithmetic shift, saturate
   logic signed [ACC_W-1:0] acc, acc_sh;
   logic                    in_range;

   assign acc = ACC_W'(p_now_ff) + ACC_W'(p_prev_ff) + ACC_W'(p_prev2_ff)
              + ACC_W'(p_int_ff);
   assign acc_sh   = acc >>> COEF_FRAC_BITS;
   assign in_range = (&acc_sh[ACC_W-1:DRIVE_BITS-1]) | ~(|acc_sh[ACC_W-1:DRIVE_BITS-1]);

   always_comb begin
      if (in_range) begin
         drive = acc_sh[DRIVE_BITS-1:0];
      end else if (acc_sh[ACC_W-1]) begin
         drive = {1'b1, {(DRIVE_BITS-1){1'b0}}};
      end else begin
         drive = {1'b0, {(DRIVE_BITS-1){1'b1}}};
      end
   end

endmodule

### dv/two_axis_pd_accel_integral_controller_unit_test.sv
// Self-checking testbench for the two-axis PD/accel/integral controller unit
`timescale 1ns / 1ps

module two_axis_pd_accel_integral_controller_unit_test;
   import tapdc_pkg::*;

   localparam int PB          = POS_BITS_DEF;
   localparam int POS_MAX     = (1 << PB) - 1;
   localparam int REQ_W       = ((4 * PB + 7) / 8) * 8;
   localparam int RSP_W       = 2 * DRIVE_BITS;
   localparam int STALL_LIMIT = 2000;

   localparam logic [COEF_BITS-1:0] COEF_MAX = 20'h7FFFF;
   localparam logic [COEF_BITS-1:0] COEF_MIN = 20'h80000;

   typedef struct {
      logic [PB-1:0] pos_x;
      logic [PB-1:0] pos_y;
      logic [PB-1:0] ref_x;
      logic [PB-1:0] ref_y;
      logic          retarget;
   } ctrl_req_type;

   typedef struct {
      logic signed [DRIVE_BITS-1:0] x;
      logic signed [DRIVE_BITS-1:0] y;
   } drive_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_W-1:0]        req_tdata  = '0;   // pos_x, pos_y, ref_x, ref_y
   logic                    req_tuser  = 1'b0; // retarget
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_W-1:0]        rsp_tdata;         // drive_x, drive_y
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index  = '0;
   logic [COEF_BITS-1:0]    csr_data   = '0;

   // predictor state: coefficients, error history and integral per axis
   logic signed [COEF_BITS-1:0] w_now   = COEF_NOW_RST;
   logic signed [COEF_BITS-1:0] w_prev  = COEF_PREV_RST;
   logic signed [COEF_BITS-1:0] w_prev2 = COEF_PREV2_RST;
   logic signed [COEF_BITS-1:0] w_integ = COEF_INT_RST;
   logic signed [ERR_BITS-1:0]  hist_now   [2] = '{0, 0};
   logic signed [ERR_BITS-1:0]  hist_prev  [2] = '{0, 0};
   logic signed [ERR_BITS-1:0]  hist_prev2 [2] = '{0, 0};
   int                          integ_sum  [2] = '{0, 0};

   ctrl_req_type   pending_reqs[$];
   drive_pair_type expected_drives[$];
   ctrl_req_type   req_item;
   drive_pair_type got_pair;
   drive_pair_type want_pair;

   int reqs_queued   = 0;
   int reqs_accepted = 0;
   int err_count     = 0;
   int req_hold      = 0;
   int rsp_hold      = 0;
   int calm_left     = 0;
   int idle_cycles   = 0;
   int traj_pos [2]  = '{2048, 2048};
   int traj_tgt [2]  = '{2048, 2048};

   two_axis_pd_accel_integral_controller_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic flag_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      err_count++;
   endtask

   // one axis: update history and integral, return the saturated drive
   function automatic logic signed [DRIVE_BITS-1:0] step_axis(input int ax,
         input logic [PB-1:0] pos, input logic [PB-1:0] tgt, input logic jump,
         input int divisor);
      logic signed [ERR_BITS-1:0] e_new;
      logic signed [ERR_BITS-1:0] d1;
      logic signed [ERR_BITS-1:0] d2;
      int     s;
      longint acc;
      longint d;
      e_new = ERR_BITS'(int'(tgt) - int'(pos));
      if (jump) begin
         // keep the history's differences, re-based on the new error
         d1 = hist_prev[ax] - hist_now[ax];
         d2 = hist_prev2[ax] - hist_prev[ax];
         integ_sum[ax] = integ_sum[ax] / 2;
         hist_now[ax]   = e_new;
         hist_prev[ax]  = e_new + d1;
         hist_prev2[ax] = hist_prev[ax] + d2;
      end else begin
         hist_prev2[ax] = hist_prev[ax];
         hist_prev[ax]  = hist_now[ax];
         hist_now[ax]   = e_new;
      end
      s = integ_sum[ax] + int'(hist_now[ax]) / divisor;
      if (s > SUM_LIMIT) s = SUM_LIMIT;
      if (s < -SUM_LIMIT) s = -SUM_LIMIT;
      integ_sum[ax] = s;
      acc = longint'(w_now) * longint'(hist_now[ax])
          + longint'(w_prev) * longint'(hist_prev[ax])
          + longint'(w_prev2) * longint'(hist_prev2[ax])
          + longint'(w_integ) * longint'(integ_sum[ax]);
      d = acc >>> COEF_FRAC_BITS_DEF;   // arithmetic shift gives the floor
      if (d > 32767) d = 32767;
      if (d < -32768) d = -32768;
      return DRIVE_BITS'(d);
   endfunction

   function automatic void predict_drives(input ctrl_req_type r);
      drive_pair_type p;
      p.x = step_axis(0, r.pos_x, r.ref_x, r.retarget, DIV_X);
      p.y = step_axis(1, r.pos_y, r.ref_y, r.retarget, DIV_Y);
      expected_drives.push_back(p);
   endfunction

   // gap length: mostly none or short, a few long, none in a calm stretch
   function automatic int pick_gap();
      int r;
      if (calm_left > 0) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   always @(posedge clock) begin
      if (reset) calm_left <= 0;
      else if (calm_left > 0) calm_left <= calm_left - 1;
      else if ($urandom_range(0, 63) == 0) calm_left <= $urandom_range(20, 80);
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_hold   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_drives(req_item);
            reqs_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_hold > 0) begin
               req_hold   <= req_hold - 1;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_item    = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {req_item.ref_y, req_item.ref_x, req_item.pos_y, req_item.pos_x};
               req_tuser  <= req_item.retarget;
               req_hold   <= pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_pair.x = rsp_tdata[DRIVE_BITS-1:0];
            got_pair.y = rsp_tdata[RSP_W-1:DRIVE_BITS];
            if (expected_drives.size() == 0) begin
               flag_error($sformatf("unexpected result x=%0d y=%0d", got_pair.x, got_pair.y));
            end else begin
               want_pair = expected_drives.pop_front();
               if (got_pair.x !== want_pair.x)
                  flag_error($sformatf("drive_x %0d, expected %0d", got_pair.x, want_pair.x));
               if (got_pair.y !== want_pair.y)
                  flag_error($sformatf("drive_y %0d, expected %0d", got_pair.y, want_pair.y));
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold   <= rsp_hold - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rsp_hold <= pick_gap();
         end
      end
   end

   // watchdog: too long without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("two_axis_pd_accel_integral_controller_unit_test: done, errors");
         $finish;
      end
   end

   task automatic queue_item(input int px, input int py, input int tx, input int ty,
         input logic rt);
      ctrl_req_type r;
      r.pos_x    = PB'(px);
      r.pos_y    = PB'(py);
      r.ref_x    = PB'(tx);
      r.ref_y    = PB'(ty);
      r.retarget = rt;
      pending_reqs.push_back(r);
      reqs_queued++;
   endtask

   // mostly tracking runs towards a target with occasional jumps, some noise
   task automatic queue_random(input int count);
      int i;
      int ax;
      int rt;
      int step;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 3) begin
            queue_item($urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
         end else begin
            rt = 0;
            if ($urandom_range(0, 7) == 0) begin
               for (ax = 0; ax < 2; ax++)
                  traj_tgt[ax] = ($urandom_range(0, 3) == 0) ?
                                 ($urandom_range(0, 1) ? POS_MAX : 0) :
                                 $urandom_range(0, POS_MAX);
               rt = int'($urandom_range(0, 5) != 0);   // now and then a jump without the flag
            end else if ($urandom_range(0, 31) == 0) begin
               rt = 1;   // flag with no real jump
            end
            for (ax = 0; ax < 2; ax++) begin
               step = (traj_tgt[ax] - traj_pos[ax]) / int'($urandom_range(2, 8));
               traj_pos[ax] = traj_pos[ax] + step + int'($urandom_range(0, 40)) - 20;
               if (traj_pos[ax] < 0) traj_pos[ax] = 0;
               if (traj_pos[ax] > POS_MAX) traj_pos[ax] = POS_MAX;
            end
            queue_item(traj_pos[0], traj_pos[1], traj_tgt[0], traj_tgt[1], rt[0]);
         end
      end
   endtask

   task automatic wait_drained();
      while (reqs_accepted != reqs_queued || expected_drives.size() != 0)
         @(posedge clock);
   endtask

   // single register write; called just after a rising edge
   task automatic write_coef(input reg_idx_type idx, input logic [COEF_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_ERR_NOW:   w_now   = val;
         REG_ERR_PREV:  w_prev  = val;
         REG_ERR_BACK2: w_prev2 = val;
         REG_INTEGRAL:  w_integ = val;
      endcase
      @(posedge clock);
   endtask

   task automatic load_coefs(input logic [COEF_BITS-1:0] c_now,
         input logic [COEF_BITS-1:0] c_prev, input logic [COEF_BITS-1:0] c_prev2,
         input logic [COEF_BITS-1:0] c_integ);
      write_coef(REG_ERR_NOW, c_now);
      write_coef(REG_ERR_PREV, c_prev);
      write_coef(REG_ERR_BACK2, c_prev2);
      write_coef(REG_INTEGRAL, c_integ);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, integral saturation both ways, retarget cases
      queue_item(0, 0, 0, 0, 1'b0);
      repeat (3) queue_item(0, 0, POS_MAX, POS_MAX, 1'b0);
      queue_item(POS_MAX, POS_MAX, 0, 0, 1'b1);
      repeat (3) queue_item(POS_MAX, POS_MAX, 0, 0, 1'b0);
      queue_item(25, 25, 0, 0, 1'b1);
      queue_item(13, 13, 0, 0, 1'b0);
      queue_item(0, 0, POS_MAX, POS_MAX, 1'b1);
      queue_item(POS_MAX, 0, 0, POS_MAX, 1'b1);
      queue_item(0, POS_MAX, POS_MAX, 0, 1'b1);
      queue_item(POS_MAX, POS_MAX, POS_MAX, POS_MAX, 1'b1);
      queue_item(12'h555, 12'hAAA, 12'hAAA, 12'h555, 1'b0);
      queue_item(12'hAAA, 12'h555, 12'h555, 12'hAAA, 1'b0);
      queue_item(0, POS_MAX, POS_MAX, 0, 1'b0);
      queue_item(POS_MAX, 0, 0, POS_MAX, 1'b0);
      queue_item(7, 7, 0, 0, 1'b1);
      queue_random(100);
      wait_drained();

      // coefficient settings, extremes first
      load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      queue_random(105);
      wait_drained();
      load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
      queue_random(105);
      wait_drained();
      load_coefs(COEF_MAX, COEF_MIN, '0, '1);
      queue_random(105);
      wait_drained();
      load_coefs(COEF_BITS'($urandom), COEF_BITS'($urandom), COEF_BITS'($urandom),
                 COEF_BITS'($urandom));
      queue_random(105);
      wait_drained();
      load_coefs(COEF_BITS'(int'($urandom_range(0, 262143)) - 131072),
                 COEF_BITS'(int'($urandom_range(0, 262143)) - 131072),
                 COEF_BITS'(int'($urandom_range(0, 262143)) - 131072),
                 COEF_BITS'(int'($urandom_range(0, 262143)) - 131072));
      queue_random(105);
      wait_drained();
      load_coefs(COEF_NOW_RST, COEF_PREV_RST, COEF_PREV2_RST, COEF_INT_RST);
      queue_random(105);
      wait_drained();

      repeat (8) @(posedge clock);
      if (err_count == 0)
         $display("two_axis_pd_accel_integral_controller_unit_test: done, clean");
      else
         $display("two_axis_pd_accel_integral_controller_unit_test: done, errors");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/tapdc_pkg.sv
rtl/tapdc_csr.sv
rtl/tapdc_lane.sv
rtl/two_axis_pd_accel_integral_controller_unit.sv
dv/two_axis_pd_accel_integral_controller_unit_test.sv
